// ===== design/forward_substring_search_top_defines.svh =====
`ifndef FORWARD_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define FORWARD_SUBSTRING_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTH
`define FSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fss check failed");
`define FSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fss check failed");
`else
`define FSS_ASSERT_IMP(label, ante, cons)
`define FSS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/fss_pkg.sv =====
package fss_pkg;

    localparam int NEEDLE_MAX = 256;
    localparam int NDL_IDX_W  = $clog2(NEEDLE_MAX);
    localparam int LEN_W      = $clog2(NEEDLE_MAX) + 1;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 32;
    localparam int GRP_SIZE   = 16;
    localparam int GRP_CNT    = NEEDLE_MAX / GRP_SIZE;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    typedef struct packed {
        logic              shift_en;
        logic              rot_en;
        logic              cap_en;
        logic              wr_en;
        logic [BYTE_W-1:0] wr_data;
    } cell_ctrl_t;

endpackage

// ===== design/forward_substring_search_top.sv =====
// Streaming first-occurrence substring search.
// Input channel (in_valid/in_stall) carries one beat per item: opcode selects
// needle load (needle_slot, data_byte), haystack byte (data_byte) or end of
// haystack. Output channel (out_valid/out_stall) carries found and
// match_position. Config channel (cfg_valid/cfg_ready) writes needle_length.
// A row of 256 cells holds the haystack window and the needle, stored in
// reverse and aligned to the current length; every cell compares its window
// byte with its needle byte on each haystack beat, and a two-level AND tree
// merges the cell results.
// Throughput: one item per cycle while in_stall is low. An accepted byte or
// end item moves through stage 1 and stage 2 to the output register.
// A length write rotates the needle row one cell per cycle, and in_stall
// stays high until the row is aligned to the new length.
// Reset clears the length, the position counter and the pipeline; needle
// bytes must be loaded before they are matched.
// When out_stall is high while out_valid is high the result holds, and the
// input keeps accepting until the two internal stages are full, then raises in_stall.
`include "forward_substring_search_top_defines.svh"

module forward_substring_search_top
    import fss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [NDL_IDX_W-1:0] needle_slot,
    input  logic [BYTE_W-1:0]    data_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 found,
    output logic [POS_W-1:0]     match_position,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LEN_W-1:0]     needle_length
);

    logic [LEN_W-1:0]     len_reg;
    logic [NDL_IDX_W-1:0] align_reg;
    logic [POS_W-1:0]     seen_reg;
    logic [POS_W-1:0]     seen_next;
    logic                 rep_reg;
    logic                 rep_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_end_reg;
    logic                 s1_elig_reg;
    logic                 s1_empty_reg;
    logic [POS_W-1:0]     s1_pos_reg;

    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    logic                 s2_end_reg;
    logic                 s2_elig_reg;
    logic                 s2_empty_reg;
    logic [POS_W-1:0]     s2_pos_reg;
    logic [GRP_CNT-1:0]   grp_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 found_reg;
    logic [POS_W-1:0]     pos_reg;

    logic                 rot_busy;
    logic                 in_fire;
    logic                 ld_fire;
    logic                 byte_fire;
    logic                 end_fire;
    logic                 push;
    logic                 out_ready;
    logic                 s1_ready;
    logic                 s2_ready;
    logic                 s2_take;
    logic                 res_valid;
    logic                 res_found;
    logic [POS_W-1:0]     res_pos;
    logic                 byte_elig;
    logic [NDL_IDX_W-1:0] wr_addr;

    cell_ctrl_t           cell_ctrl;
    logic [NEEDLE_MAX-1:0] ok_bits;
    logic [NEEDLE_MAX-1:0] sel_bits;
    logic [NEEDLE_MAX-1:0] active_bits;
    logic [GRP_CNT-1:0]   grp_and;
    logic [BYTE_W-1:0]    win_out [NEEDLE_MAX];
    logic [BYTE_W-1:0]    ndl_out [NEEDLE_MAX];

    assign cfg_ready = 1'b1;
    assign rot_busy  = (align_reg != len_reg[NDL_IDX_W-1:0]);

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = rot_busy || !s1_ready;
    assign in_fire   = in_valid && !in_stall;

    always_comb
    begin
        ld_fire   = 1'b0;
        byte_fire = 1'b0;
        end_fire  = 1'b0;
        case (opcode)
            OP_LOAD: ld_fire   = in_fire;
            OP_BYTE: byte_fire = in_fire;
            OP_END:  end_fire  = in_fire;
            default: ;
        endcase
    end

    assign push    = byte_fire || end_fire;
    assign wr_addr = len_reg[NDL_IDX_W-1:0] - NDL_IDX_W'(1) - needle_slot;

    assign seen_next = (seen_reg == POS_MAX) ? seen_reg : seen_reg + POS_W'(1);
    assign byte_elig = (len_reg != '0) && (len_reg <= LEN_W'(NEEDLE_MAX))
                       && (seen_next >= POS_W'(len_reg));

    always_comb
    begin
        cell_ctrl.shift_en = byte_fire;
        cell_ctrl.rot_en   = rot_busy;
        cell_ctrl.cap_en   = byte_fire;
        cell_ctrl.wr_en    = ld_fire;
        cell_ctrl.wr_data  = data_byte;
    end

    genvar j;
    generate
        for (j = 0; j < NEEDLE_MAX; j++)
        begin : g_cell
            logic [BYTE_W-1:0] win_in;
            logic [BYTE_W-1:0] ndl_in;

            if (j == 0)
            begin : g_head
                assign win_in = data_byte;
                assign ndl_in = ndl_out[NEEDLE_MAX-1];
            end
            else
            begin : g_body
                assign win_in = win_out[j-1];
                assign ndl_in = ndl_out[j-1];
            end

            assign sel_bits[j]    = (wr_addr == NDL_IDX_W'(j));
            assign active_bits[j] = (LEN_W'(j) < len_reg);

            fss_cell u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl),
                .sel     (sel_bits[j]),
                .active  (active_bits[j]),
                .win_in  (win_in),
                .ndl_in  (ndl_in),
                .win_out (win_out[j]),
                .ndl_out (ndl_out[j]),
                .ok      (ok_bits[j])
            );
        end

        for (j = 0; j < GRP_CNT; j++)
        begin : g_grp
            assign grp_and[j] = &ok_bits[j*GRP_SIZE +: GRP_SIZE];
        end
    endgenerate

    assign s1_valid_next = push || (s1_valid_reg && !s2_ready);
    assign s2_valid_next = (s1_valid_reg && s2_ready) || (s2_valid_reg && !out_ready);
    assign s2_take       = s2_valid_reg && out_ready;

    always_comb
    begin
        res_valid = 1'b0;
        res_found = 1'b0;
        res_pos   = '0;
        rep_next  = rep_reg;
        if (s2_take)
        begin
            if (s2_end_reg)
            begin
                res_valid = !rep_reg;
                res_found = s2_empty_reg;
                rep_next  = 1'b0;
            end
            else
            begin
                res_valid = !rep_reg && s2_elig_reg && (&grp_reg);
                res_found = 1'b1;
                res_pos   = s2_pos_reg;
                rep_next  = rep_reg || res_valid;
            end
        end
    end

    assign out_valid_next = s2_take ? res_valid : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            align_reg     <= '0;
            seen_reg      <= '0;
            rep_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                len_reg <= needle_length;
            end
            if (rot_busy)
            begin
                align_reg <= align_reg + NDL_IDX_W'(1);
            end
            if (byte_fire)
            begin
                seen_reg <= seen_next;
            end
            else if (end_fire)
            begin
                seen_reg <= '0;
            end
            rep_reg       <= rep_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            s1_end_reg   <= end_fire;
            s1_elig_reg  <= byte_elig;
            s1_empty_reg <= (len_reg == '0);
            s1_pos_reg   <= seen_next - POS_W'(len_reg);
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_end_reg   <= s1_end_reg;
            s2_elig_reg  <= s1_elig_reg;
            s2_empty_reg <= s1_empty_reg;
            s2_pos_reg   <= s1_pos_reg;
            grp_reg      <= grp_and;
        end
        if (s2_take && res_valid)
        begin
            found_reg <= res_found;
            pos_reg   <= res_pos;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign match_position = pos_reg;

    `FSS_ASSERT_IMP(a_rep_rise_found, $rose(rep_reg), out_valid_reg && found_reg)
    `FSS_ASSERT_IMP(a_rep_fall_end, $fell(rep_reg), $past(s2_take && s2_end_reg))
    `FSS_ASSERT_NEXT(a_len_write_rotates,
        cfg_valid && cfg_ready && !rot_busy
        && (needle_length[NDL_IDX_W-1:0] != align_reg), rot_busy)
    `FSS_ASSERT_IMP(a_no_load_while_rot, rot_busy, !ld_fire && !push)

endmodule

// ===== design/fss_cell.sv =====
module fss_cell
    import fss_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic              sel,
    input  logic              active,
    input  logic [BYTE_W-1:0] win_in,
    input  logic [BYTE_W-1:0] ndl_in,
    output logic [BYTE_W-1:0] win_out,
    output logic [BYTE_W-1:0] ndl_out,
    output logic              ok
);

    logic [BYTE_W-1:0] win_reg;
    logic [BYTE_W-1:0] ndl_reg;
    logic              ok_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            win_reg <= win_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rot_en)
        begin
            ndl_reg <= ndl_in;
        end
        else if (ctrl.wr_en && sel)
        begin
            ndl_reg <= ctrl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_en)
        begin
            ok_reg <= !active || (win_in == ndl_reg);
        end
    end

    assign win_out = win_reg;
    assign ndl_out = ndl_reg;
    assign ok      = ok_reg;

endmodule
